// File: src/gbn_pkg.sv
`timescale 1ns / 1ps
package gbn_pkg;

    localparam int MAX_WINDOW  = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam int SEQ_W    = 16;
    localparam int TICK_W   = 16;
    localparam int LIMIT_W  = 4;
    localparam int FLIGHT_W = 4;
    localparam int ACTION_W = 3;
    localparam int OPCODE_W = 2;
    localparam int KIND_W   = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    // outstanding count must hold MAX_WINDOW itself
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    localparam logic [LIMIT_W-1:0] WINDOW_LIMIT_RST  = LIMIT_W'(8);
    localparam logic [TICK_W-1:0]  TIMEOUT_TICKS_RST = TICK_W'(200);

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LIMIT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 1'd1;

    localparam logic [OPCODE_W-1:0] OP_OFFER = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_ACK   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_START = 2'd3;

    localparam logic [ACTION_W-1:0] ACT_SEND       = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_REFUSED    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_TAKEN      = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_IGNORED    = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_COMPLETE   = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_RETRANSMIT = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_DROPPED    = 3'd6;

    // command classes handed from front to back
    localparam logic [KIND_W-1:0] K_OFFER     = 3'd0;
    localparam logic [KIND_W-1:0] K_DROP      = 3'd1;
    localparam logic [KIND_W-1:0] K_ACK_FINAL = 3'd2;
    localparam logic [KIND_W-1:0] K_ACK       = 3'd3;
    localparam logic [KIND_W-1:0] K_TICK      = 3'd4;
    localparam logic [KIND_W-1:0] K_START     = 3'd5;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              is_final;
        logic [SEQ_W-1:0]  ack_number;
    } cmd_t;

    typedef struct packed {
        logic                valid;
        logic [ACTION_W-1:0] action;
        logic [SEQ_W-1:0]    sequence_res;
        logic [FLIGHT_W-1:0] in_flight;
        logic                last;
    } res_t;

endpackage

// File: src/gbn_front.sv
`timescale 1ns / 1ps
module gbn_front
(
    input  logic                           start,
    input  logic                           full,
    input  logic [gbn_pkg::OPCODE_W-1:0]   opcode,
    input  logic                           is_final_packet,
    input  logic [gbn_pkg::SEQ_W-1:0]      ack_number,
    input  logic                           ack_final_flag,
    input  logic                           checksum_good,
    output logic                           push,
    output gbn_pkg::cmd_t                  cmd
);
    import gbn_pkg::*;

    assign push = start & ~full;

    // bad checksum beats the final flag, which beats number matching
    always_comb
    begin
        cmd.is_final   = is_final_packet;
        cmd.ack_number = ack_number;
        case (opcode)
            OP_OFFER: cmd.kind = K_OFFER;
            OP_TICK:  cmd.kind = K_TICK;
            OP_START: cmd.kind = K_START;
            OP_ACK:
            begin
                if (!checksum_good)
                    cmd.kind = K_DROP;
                else if (ack_final_flag)
                    cmd.kind = K_ACK_FINAL;
                else
                    cmd.kind = K_ACK;
            end
            default: cmd.kind = K_TICK;
        endcase
    end

endmodule

// File: src/gbn_cmd_fifo.sv
`timescale 1ns / 1ps
module gbn_cmd_fifo
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  gbn_pkg::cmd_t wr_cmd,
    input  logic          pop,
    output gbn_pkg::cmd_t rd_cmd,
    output logic          empty,
    output logic          full
);
    import gbn_pkg::*;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              do_push;
    logic              do_pop;

    assign empty   = (fill_reg == '0);
    assign full    = (fill_reg == FILL_MAX);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign rd_cmd  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                fill_reg <= fill_reg + 1'b1;
            else if (do_pop && !do_push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full && !pop |=> full)
        else $error("queue lost an entry while full");
`endif

endmodule

// File: src/gbn_back.sv
`timescale 1ns / 1ps
module gbn_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  gbn_pkg::cmd_t                 cmd,
    input  logic                          empty,
    input  logic [gbn_pkg::LIMIT_W-1:0]   window_limit,
    input  logic [gbn_pkg::TICK_W-1:0]    timeout_ticks,
    output logic                          pop,
    output gbn_pkg::res_t                 res
);
    import gbn_pkg::*;

    logic [SEQ_W-1:0]    next_seq_reg,  next_seq_next;
    logic [SEQ_W-1:0]    base_reg,      base_next;
    logic [CNT_W-1:0]    count_reg,     count_next;
    logic                finished_reg,  finished_next;
    logic [TICK_W-1:0]   elapsed_reg,   elapsed_next;
    logic                burst_reg,     burst_next;
    logic [CNT_W-1:0]    idx_reg,       idx_next;
    res_t                res_reg,       res_next;

    logic [LIM_W-1:0]    eff_limit;
    logic                window_full;
    logic                burst_end;

    always_comb
    begin
        if (window_limit == '0)
            eff_limit = LIM_W'(1);
        else if (LIM_W'(window_limit) > LIM_W'(MAX_WINDOW))
            eff_limit = LIM_W'(MAX_WINDOW);
        else
            eff_limit = LIM_W'(window_limit);
    end

    assign window_full = (LIM_W'(count_reg) >= eff_limit);
    assign burst_end   = (idx_reg == count_reg - CNT_W'(1));

    always_comb
    begin
        next_seq_next = next_seq_reg;
        base_next     = base_reg;
        count_next    = count_reg;
        finished_next = finished_reg;
        elapsed_next  = elapsed_reg;
        burst_next    = burst_reg;
        idx_next      = idx_reg;
        pop           = 1'b0;
        res_next.valid        = 1'b0;
        res_next.action       = ACT_IGNORED;
        res_next.sequence_res = '0;
        res_next.last         = 1'b1;

        if (burst_reg)
        begin
            res_next.valid        = 1'b1;
            res_next.action       = ACT_RETRANSMIT;
            res_next.sequence_res = base_reg + SEQ_W'(idx_reg);
            res_next.last         = burst_end;
            if (burst_end)
                burst_next = 1'b0;
            else
                idx_next = idx_reg + 1'b1;
        end
        else if (!empty)
        begin
            pop = 1'b1;
            case (cmd.kind)
                K_OFFER:
                begin
                    res_next.valid = 1'b1;
                    if (finished_reg || window_full)
                        res_next.action = ACT_REFUSED;
                    else
                    begin
                        res_next.action       = ACT_SEND;
                        res_next.sequence_res = next_seq_reg;
                        next_seq_next = next_seq_reg + 1'b1;
                        count_next    = count_reg + 1'b1;
                        elapsed_next  = '0;
                        if (cmd.is_final)
                            finished_next = 1'b1;
                    end
                end
                K_DROP:
                begin
                    res_next.valid  = 1'b1;
                    res_next.action = ACT_DROPPED;
                end
                K_ACK_FINAL:
                begin
                    res_next.valid  = 1'b1;
                    res_next.action = ACT_COMPLETE;
                    count_next      = '0;
                end
                K_ACK:
                begin
                    res_next.valid = 1'b1;
                    if (cmd.ack_number == base_reg)
                    begin
                        if (count_reg != '0)
                        begin
                            res_next.action = ACT_TAKEN;
                            base_next    = base_reg + 1'b1;
                            count_next   = count_reg - 1'b1;
                            elapsed_next = '0;
                        end
                    end
                    else if (elapsed_reg > timeout_ticks && count_reg != '0)
                    begin
                        // first number goes out now, the rest one a cycle
                        res_next.action       = ACT_RETRANSMIT;
                        res_next.sequence_res = base_reg;
                        res_next.last         = (count_reg == CNT_W'(1));
                        burst_next   = (count_reg != CNT_W'(1));
                        idx_next     = CNT_W'(1);
                        elapsed_next = '0;
                    end
                end
                K_TICK:
                begin
                    if (elapsed_reg != {TICK_W{1'b1}})
                        elapsed_next = elapsed_reg + 1'b1;
                end
                K_START:
                begin
                    next_seq_next = '0;
                    base_next     = '0;
                    count_next    = '0;
                    finished_next = 1'b0;
                    elapsed_next  = '0;
                end
                default:
                begin
                    res_next.valid = 1'b0;
                end
            endcase
        end
        res_next.in_flight = FLIGHT_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_seq_reg <= '0;
            base_reg     <= '0;
            count_reg    <= '0;
            finished_reg <= 1'b0;
            elapsed_reg  <= '0;
            burst_reg    <= 1'b0;
            idx_reg      <= '0;
            res_reg      <= '0;
        end
        else
        begin
            next_seq_reg <= next_seq_next;
            base_reg     <= base_next;
            count_reg    <= count_next;
            finished_reg <= finished_next;
            elapsed_reg  <= elapsed_next;
            burst_reg    <= burst_next;
            idx_reg      <= idx_next;
            res_reg      <= res_next;
        end
    end

    assign res = res_reg;

`ifndef SYNTHESIS
    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        res_reg.valid && !res_reg.last |=> res_reg.valid)
        else $error("retransmit burst broken off");
    a_burst_consecutive: assert property (@(posedge clk) disable iff (!rst_n)
        res_reg.valid && !res_reg.last |=>
            res_reg.action == ACT_RETRANSMIT &&
            res_reg.sequence_res == $past(res_reg.sequence_res) + SEQ_W'(1))
        else $error("retransmitted numbers not consecutive");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_WINDOW))
        else $error("outstanding count beyond window");
    a_no_pop_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        burst_reg |-> !pop && $stable(count_reg))
        else $error("command taken during retransmit burst");
`endif

endmodule

// File: src/go_back_n_sender_window_core.sv
`timescale 1ns / 1ps
// Channel   Handshake              Transaction on
// command   start / busy           rising edge with start high, busy low
// result    done (strobe)          the one cycle done is high
// config    cfg_valid / cfg_ready  rising edge with both high
//
// A command is written into the queue; the back end takes it from the queue head
// while no retransmit burst runs, and its result, if it has one, is registered onto
// the ports. The back end takes one command per cycle, except in a retransmit,
// which puts out one outstanding number per cycle (up to the window).
// busy rises only while the two-entry command queue is full.
// Reset clears the window state and loads window_limit 8, timeout_ticks 200.
// Results cannot be held off; done is high for exactly one cycle per result.
module go_back_n_sender_window_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [gbn_pkg::OPCODE_W-1:0]      opcode,
    input  logic                              is_final_packet,
    input  logic [gbn_pkg::SEQ_W-1:0]         ack_number,
    input  logic                              ack_final_flag,
    input  logic                              checksum_good,
    output logic                              done,
    output logic [gbn_pkg::ACTION_W-1:0]      action,
    output logic [gbn_pkg::SEQ_W-1:0]         sequence_res,
    output logic [gbn_pkg::FLIGHT_W-1:0]      in_flight,
    output logic                              last_result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gbn_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gbn_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import gbn_pkg::*;

    logic [LIMIT_W-1:0] window_limit_reg;
    logic [TICK_W-1:0]  timeout_ticks_reg;
    logic               q_full;
    logic               q_empty;
    logic               q_push;
    logic               q_pop;
    cmd_t               front_cmd;
    cmd_t               back_cmd;
    res_t               res;

    assign cfg_ready = 1'b1;
    assign busy      = q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_limit_reg  <= WINDOW_LIMIT_RST;
            timeout_ticks_reg <= TIMEOUT_TICKS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WINDOW_LIMIT:  window_limit_reg  <= cfg_data[LIMIT_W-1:0];
                REG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data[TICK_W-1:0];
                default:           window_limit_reg  <= window_limit_reg;
            endcase
        end
    end

    gbn_front u_front
    (
        .start           (start),
        .full            (q_full),
        .opcode          (opcode),
        .is_final_packet (is_final_packet),
        .ack_number      (ack_number),
        .ack_final_flag  (ack_final_flag),
        .checksum_good   (checksum_good),
        .push            (q_push),
        .cmd             (front_cmd)
    );

    gbn_cmd_fifo u_fifo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wr_cmd (front_cmd),
        .pop    (q_pop),
        .rd_cmd (back_cmd),
        .empty  (q_empty),
        .full   (q_full)
    );

    gbn_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (back_cmd),
        .empty         (q_empty),
        .window_limit  (window_limit_reg),
        .timeout_ticks (timeout_ticks_reg),
        .pop           (q_pop),
        .res           (res)
    );

    assign done         = res.valid;
    assign action       = res.action;
    assign sequence_res = res.sequence_res;
    assign in_flight    = res.in_flight;
    assign last_result  = res.last;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import gbn_pkg::*;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int DRAIN_CYCLES = 24;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SEQ_W-1:0]    seq;
        logic [FLIGHT_W-1:0] flight;
        logic                last;
    } outcome_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [OPCODE_W-1:0]   opcode = OP_TICK;
    logic                  is_final_packet = 1'b0;
    logic [SEQ_W-1:0]      ack_number = '0;
    logic                  ack_final_flag = 1'b0;
    logic                  checksum_good = 1'b0;
    logic                  done;
    logic [ACTION_W-1:0]   action;
    logic [SEQ_W-1:0]      sequence_res;
    logic [FLIGHT_W-1:0]   in_flight;
    logic                  last_result;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_WINDOW_LIMIT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // window state as the block should hold it
    logic [LIMIT_W-1:0] limit_reg = WINDOW_LIMIT_RST;
    logic [TICK_W-1:0]  timeout_reg = TIMEOUT_TICKS_RST;
    logic [SEQ_W-1:0]   next_seq = '0;
    logic [SEQ_W-1:0]   base_seq = '0;
    int unsigned        flight = 0;
    logic               finished = 1'b0;
    logic [TICK_W-1:0]  ticks_seen = '0;

    outcome_t expected_outcomes[$];
    outcome_t got;
    outcome_t want;
    int       error_count = 0;
    int       cycle_count = 0;
    int       idle_pct = 0;

    go_back_n_sender_window_core uut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .opcode          (opcode),
        .is_final_packet (is_final_packet),
        .ack_number      (ack_number),
        .ack_final_flag  (ack_final_flag),
        .checksum_good   (checksum_good),
        .done            (done),
        .action          (action),
        .sequence_res    (sequence_res),
        .in_flight       (in_flight),
        .last_result     (last_result),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic void queue_outcome(input logic [ACTION_W-1:0] act,
                                          input logic [SEQ_W-1:0] seq,
                                          input logic last);
        outcome_t o;
        o.action = act;
        o.seq    = seq;
        o.flight = flight[FLIGHT_W-1:0];
        o.last   = last;
        expected_outcomes.push_back(o);
    endfunction

    function automatic void predict_window(input logic [OPCODE_W-1:0] op,
                                           input logic fin,
                                           input logic [SEQ_W-1:0] ackn,
                                           input logic afin,
                                           input logic good);
        int unsigned eff;
        int unsigned n;
        eff = (limit_reg == 0) ? 1 : ((limit_reg > MAX_WINDOW) ? MAX_WINDOW : limit_reg);
        case (op)
            OP_OFFER:
            begin
                if (finished || flight >= eff)
                    queue_outcome(ACT_REFUSED, '0, 1'b1);
                else
                begin
                    flight = flight + 1;
                    queue_outcome(ACT_SEND, next_seq, 1'b1);
                    next_seq   = next_seq + 1'b1;
                    ticks_seen = '0;
                    if (fin)
                        finished = 1'b1;
                end
            end
            OP_TICK:
            begin
                if (ticks_seen != '1)
                    ticks_seen = ticks_seen + 1'b1;
            end
            OP_START:
            begin
                next_seq   = '0;
                base_seq   = '0;
                flight     = 0;
                finished   = 1'b0;
                ticks_seen = '0;
            end
            OP_ACK:
            begin
                if (!good)
                    queue_outcome(ACT_DROPPED, '0, 1'b1);
                else if (afin)
                begin
                    flight = 0;
                    queue_outcome(ACT_COMPLETE, '0, 1'b1);
                end
                else if (ackn == base_seq)
                begin
                    if (flight == 0)
                        queue_outcome(ACT_IGNORED, '0, 1'b1);
                    else
                    begin
                        base_seq   = base_seq + 1'b1;
                        flight     = flight - 1;
                        ticks_seen = '0;
                        queue_outcome(ACT_TAKEN, '0, 1'b1);
                    end
                end
                else if (ticks_seen > timeout_reg && flight > 0)
                begin
                    n = (flight > MAX_WINDOW) ? MAX_WINDOW : flight;
                    for (int unsigned i = 0; i < n; i++)
                        queue_outcome(ACT_RETRANSMIT, base_seq + i[SEQ_W-1:0], i + 1 == n);
                    ticks_seen = '0;
                end
                else
                    queue_outcome(ACT_IGNORED, '0, 1'b1);
            end
            default: ;
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            got = {action, sequence_res, in_flight, last_result};
            if (expected_outcomes.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("%0t unexpected result: action %0d seq %0d in_flight %0d %s%0d",
                             $realtime, got.action, got.seq, got.flight, "last ", got.last);
            end
            else
            begin
                want = expected_outcomes.pop_front();
                if (got !== want)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display({"%0t mismatch: expected action %0d seq %0d in_flight %0d",
                                  " last %0d; got action %0d seq %0d in_flight %0d last %0d"},
                                 $realtime, want.action, want.seq, want.flight, want.last,
                                 got.action, got.seq, got.flight, got.last);
                end
            end
        end
    end

    // one command transaction; returns at the edge that accepts it
    task automatic send_cmd(input logic [OPCODE_W-1:0] op, input logic fin,
                            input logic [SEQ_W-1:0] ackn, input logic afin,
                            input logic good);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        start           <= 1'b1;
        opcode          <= op;
        is_final_packet <= fin;
        ack_number      <= ackn;
        ack_final_flag  <= afin;
        checksum_good   <= good;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_window(op, fin, ackn, afin, good);
    endtask

    task automatic offer(input logic fin);
        send_cmd(OP_OFFER, fin, SEQ_W'($urandom_range(65535)), 1'($urandom_range(1)),
                 1'($urandom_range(1)));
    endtask

    task automatic ack(input logic [SEQ_W-1:0] num);
        send_cmd(OP_ACK, 1'($urandom_range(1)), num, 1'b0, 1'b1);
    endtask

    task automatic tick();
        send_cmd(OP_TICK, 1'($urandom_range(1)), SEQ_W'($urandom_range(65535)),
                 1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    task automatic restart();
        send_cmd(OP_START, 1'($urandom_range(1)), SEQ_W'($urandom_range(65535)),
                 1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    // wait for the block to go quiet; ticks and starts leave no result behind
    task automatic settle();
        start <= 1'b0;
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic [CFG_DATA_W-1:0] lim_val,
                                input logic [CFG_DATA_W-1:0] tmo_val);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= REG_WINDOW_LIMIT;
        cfg_data  <= lim_val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        limit_reg = lim_val[LIMIT_W-1:0];
        cfg_index <= REG_TIMEOUT_TICKS;
        cfg_data  <= tmo_val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        timeout_reg = tmo_val;
        cfg_valid <= 1'b0;
    endtask

    task automatic test_basics();
        ack(16'd0);                              // matching number, empty window
        ack(16'hFFFF);                           // mismatch, empty window
        send_cmd(OP_ACK, 1'b1, 16'd0, 1'b1, 1'b0); // bad checksum beats final flag
        repeat (8) offer(1'b0);
        offer(1'b0);                             // window full
        ack(16'd0);
        ack(16'h8000);                           // mismatch before timeout
        offer(1'b1);                             // final packet
        offer(1'b0);                             // refused, transfer finished
        send_cmd(OP_ACK, 1'b0, 16'h7FFF, 1'b1, 1'b1);
        offer(1'b0);                             // still finished until start
        restart();
        offer(1'b0);
    endtask

    task automatic test_window_limit();
        write_config(16'h0000, 16'd200);         // zero behaves as one
        restart();
        offer(1'b0);
        offer(1'b0);
        ack(16'd0);
        offer(1'b0);
        write_config(16'hABCF, 16'hFFFF);        // 15 clamps to the maximum window
        restart();
        repeat (9) offer(1'b0);
        write_config(16'h5431, 16'h0000);
        restart();
        offer(1'b0);
        offer(1'b0);
    endtask

    task automatic test_timeout();
        write_config(16'd8, 16'd1);
        restart();
        repeat (3) offer(1'b0);
        tick();
        ack(16'h00F0);                           // one tick is not past the limit
        tick();
        ack(16'h00F0);                           // retransmit 0..2
        ack(16'h00F0);                           // timer restarted by the burst
        tick();
        tick();
        ack(16'd0);
        tick();
        tick();
        ack(16'hF00F);                           // retransmit 1..2
        tick();
        tick();
        offer(1'b0);                             // send restarts the timer
        ack(16'hF00F);
        send_cmd(OP_ACK, 1'b1, 16'h0ABC, 1'b1, 1'b1);
        tick();
        tick();
        ack(16'h1234);                           // timed out but nothing outstanding
    endtask

    task automatic random_phase(input int count, input int pct, input logic [3:0] lim,
                                input logic [CFG_DATA_W-1:0] tmo);
        logic [CFG_DATA_W-1:0] lim_data;
        int                    pick;
        int                    sub;
        lim_data      = CFG_DATA_W'($urandom_range(65535));
        lim_data[3:0] = lim;
        write_config(lim_data, tmo);
        idle_pct = pct;
        restart();
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 3)
                restart();
            else if (pick < 33)
                offer($urandom_range(29) == 0);
            else if (pick < 60)
                tick();
            else
            begin
                sub = $urandom_range(99);
                if (sub < 8)
                    send_cmd(OP_ACK, 1'($urandom_range(1)), SEQ_W'($urandom_range(65535)),
                             1'($urandom_range(1)), 1'b0);
                else if (sub < 13)
                    send_cmd(OP_ACK, 1'($urandom_range(1)), SEQ_W'($urandom_range(65535)),
                             1'b1, 1'b1);
                else if (sub < 63)
                    ack(base_seq);
                else if (sub < 80)
                    ack(SEQ_W'(base_seq + $urandom_range(1, 3)));
                else
                    ack(SEQ_W'($urandom_range(65535)));
            end
        end
        idle_pct = 0;
    endtask

    task automatic test_random_traffic();
        random_phase(69, 0, 4'd8, 16'd3);
        random_phase(69, 77, 4'd1, 16'd1);
        random_phase(69, 22, 4'd0, 16'd5);
        random_phase(69, 0, 4'd15, CFG_DATA_W'($urandom_range(2, 10)));
        random_phase(69, 77, 4'($urandom_range(2, 7)), CFG_DATA_W'($urandom_range(1, 12)));
        random_phase(69, 22, 4'd3, 16'd0);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_basics();
        test_window_limit();
        test_timeout();
        test_random_traffic();
        settle();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: go_back_n_sender_window_core.f
src/gbn_pkg.sv
src/gbn_front.sv
src/gbn_cmd_fifo.sv
src/gbn_back.sv
src/go_back_n_sender_window_core.sv
dv/testbench.sv
